// ===== rtl/core/bmprgb_pkg.sv =====
// ----------------------------------------------------------------------------
// bmprgb_pkg
// Shared widths, register indexes, job descriptor and colour packing for the
// BMP row to RGB565 converter.
// ----------------------------------------------------------------------------
package bmprgb_pkg;

  // field and counter widths
  localparam int BYTE_W     = 8;
  localparam int COLOR_W    = 24;
  localparam int PIX_W      = 16;
  localparam int OCOL_W     = 10;
  localparam int COL_W      = 11;
  localparam int ROW_W      = 13;
  localparam int LINE_W     = 14;
  localparam int NPIX_W     = 4;
  localparam int DEPTH_W    = 5;
  localparam int SCALE_W    = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BIT_DEPTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE       = 2'd2;

  // configuration reset values
  localparam logic [DEPTH_W-1:0] RST_BIT_DEPTH = 5'd24;
  localparam logic [COL_W-1:0]   RST_WIDTH     = 11'd320;
  localparam logic [SCALE_W-1:0] RST_SCALE     = 2'd1;

  // supported pixel depths
  localparam logic [DEPTH_W-1:0] BPP_1  = 5'd1;
  localparam logic [DEPTH_W-1:0] BPP_4  = 5'd4;
  localparam logic [DEPTH_W-1:0] BPP_8  = 5'd8;
  localparam logic [DEPTH_W-1:0] BPP_24 = 5'd24;

  // horizontal doubling
  localparam logic [SCALE_W-1:0] SCALE_X2        = 2'd2;
  localparam logic [COL_W-1:0]   SCALE_MAX_WIDTH = 11'd33;

  // request types on the input channel
  localparam logic REQ_PAL_WRITE = 1'b0;
  localparam logic REQ_DATA      = 1'b1;

  typedef enum logic [1:0] {
    MODE_DIRECT = 2'd0,
    MODE_PAL8   = 2'd1,
    MODE_PAL4   = 2'd2,
    MODE_PAL1   = 2'd3
  } pix_mode_t;

  typedef enum logic {
    JOB_PAL_WRITE = 1'b0,
    JOB_PIXELS    = 1'b1
  } job_kind_t;

  // one unit of work for the pixel generator
  typedef struct packed {
    job_kind_t           kind;
    pix_mode_t           mode;
    logic [COLOR_W-1:0]  data;      // palette colour, direct pixel or raw byte
    logic [BYTE_W-1:0]   wr_index;
    logic [NPIX_W-1:0]   npix;      // source pixels to emit, 1 to 8
    logic [COL_W-1:0]    start_col;
    logic                scale2;
    logic                row_end;   // last source pixel closes the row
  } job_t;

  function automatic logic [PIX_W-1:0] to_rgb565(input logic [COLOR_W-1:0] c);
    return {c[23:19], c[15:10], c[7:3]};
  endfunction

endpackage

// ===== rtl/core/bmprgb_ifs.sv =====
// ----------------------------------------------------------------------------
// bmprgb channel interfaces
// Valid/ready channels for incoming requests and outgoing RGB565 pixels.
// ----------------------------------------------------------------------------
interface bmprgb_in_if;
  logic                              valid;
  logic                              ready;
  logic                              req_type;
  logic [bmprgb_pkg::BYTE_W-1:0]     palette_index;
  logic [bmprgb_pkg::COLOR_W-1:0]    palette_color;
  logic [bmprgb_pkg::BYTE_W-1:0]     data_byte;

  modport source (output valid, req_type, palette_index, palette_color, data_byte,
                  input ready);
  modport sink (input valid, req_type, palette_index, palette_color, data_byte,
                output ready);
endinterface

interface bmprgb_out_if;
  logic                              valid;
  logic                              ready;
  logic [bmprgb_pkg::PIX_W-1:0]      pixel;
  logic [bmprgb_pkg::OCOL_W-1:0]     out_column;
  logic                              end_of_row;
  logic                              last_of_item;

  modport source (output valid, pixel, out_column, end_of_row, last_of_item,
                  input ready);
  modport sink (input valid, pixel, out_column, end_of_row, last_of_item,
                output ready);
endinterface

// ===== rtl/core/bmprgb_ram.sv =====
// ----------------------------------------------------------------------------
// bmprgb_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module bmprgb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic                                          re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  addr,
  input  logic [WIDTH-1:0]                              wdata,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/bmprgb_row_trk.sv =====
// ----------------------------------------------------------------------------
// bmprgb_row_trk
// Row position tracker: turns accepted items into pixel and palette-write jobs and keeps
// the source column, row byte count and BGR triplet state.
// ----------------------------------------------------------------------------
module bmprgb_row_trk #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [bmprgb_pkg::DEPTH_W-1:0]      bit_depth,
  input  logic [bmprgb_pkg::COL_W-1:0]        image_width,
  input  logic [bmprgb_pkg::SCALE_W-1:0]      scale_request,
  input  logic                                take,
  input  logic                                req_type,
  input  logic [bmprgb_pkg::BYTE_W-1:0]       palette_index,
  input  logic [bmprgb_pkg::COLOR_W-1:0]      palette_color,
  input  logic [bmprgb_pkg::BYTE_W-1:0]       data_byte,
  output bmprgb_pkg::job_t                    job,
  output logic                                job_v
);

  localparam logic [1:0] PH_BLUE  = 2'd0;
  localparam logic [1:0] PH_GREEN = 2'd1;
  localparam logic [1:0] PH_RED   = 2'd2;

  logic [bmprgb_pkg::COL_W-1:0]  w;
  logic [bmprgb_pkg::COL_W-1:0]  rem;
  logic [bmprgb_pkg::COL_W-1:0]  sc_r, sc_nxt;
  logic [bmprgb_pkg::ROW_W-1:0]  rbc_r, rbc_nxt, rbc_inc;
  logic [1:0]                    phase_r, phase_nxt;
  logic [15:0]                   held_r, held_nxt;
  logic [15:0]                   bits;
  logic [bmprgb_pkg::LINE_W-1:0] line;
  logic [bmprgb_pkg::NPIX_W-1:0] npix;
  bmprgb_pkg::pix_mode_t         mode;
  logic                          depth_ok;
  logic                          is_data;
  logic                          in_row;
  logic                          emit;
  logic                          scale2;

  // effective width, clamped to one and to the maximum
  always_comb begin
    if (image_width == '0) begin
      w = bmprgb_pkg::COL_W'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      w = bmprgb_pkg::COL_W'(MAX_WIDTH);
    end else begin
      w = image_width;
    end
  end

  assign scale2 = (scale_request == bmprgb_pkg::SCALE_X2) &&
                  (w <= bmprgb_pkg::SCALE_MAX_WIDTH);

  // bits per row and decode mode
  always_comb begin
    depth_ok = 1'b1;
    mode     = bmprgb_pkg::MODE_DIRECT;
    bits     = '0;
    unique case (bit_depth)
      bmprgb_pkg::BPP_1: begin
        mode = bmprgb_pkg::MODE_PAL1;
        bits = 16'(w);
      end
      bmprgb_pkg::BPP_4: begin
        mode = bmprgb_pkg::MODE_PAL4;
        bits = {3'b000, w, 2'b00};
      end
      bmprgb_pkg::BPP_8: begin
        mode = bmprgb_pkg::MODE_PAL8;
        bits = {2'b00, w, 3'b000};
      end
      bmprgb_pkg::BPP_24: begin
        mode = bmprgb_pkg::MODE_DIRECT;
        bits = {1'b0, w, 4'b0000} + {2'b00, w, 3'b000};
      end
      default: begin
        depth_ok = 1'b0;
      end
    endcase
  end

  // row length in bytes, padded to a multiple of four
  assign line = {(bmprgb_pkg::LINE_W-2)'((17'(bits) + 17'd31) >> 5), 2'b00};

  assign in_row  = sc_r < w;
  assign rem     = w - sc_r;
  assign is_data = (req_type == bmprgb_pkg::REQ_DATA);

  // source pixels carried by this byte
  always_comb begin
    case (mode)
      bmprgb_pkg::MODE_PAL1: npix = (rem > 11'd8) ? 4'd8 : rem[3:0];
      bmprgb_pkg::MODE_PAL4: npix = (rem > 11'd2) ? 4'd2 : rem[3:0];
      default:               npix = 4'd1;
    endcase
  end

  assign emit  = in_row && ((mode != bmprgb_pkg::MODE_DIRECT) || (phase_r == PH_RED));
  assign job_v = !is_data || (depth_ok && emit);

  // job descriptor
  always_comb begin
    job.kind      = is_data ? bmprgb_pkg::JOB_PIXELS : bmprgb_pkg::JOB_PAL_WRITE;
    job.mode      = mode;
    job.wr_index  = palette_index;
    job.npix      = npix;
    job.start_col = sc_r;
    job.scale2    = scale2;
    job.row_end   = (sc_r + bmprgb_pkg::COL_W'(npix)) == w;
    if (!is_data) begin
      job.data = palette_color;
    end else if (mode == bmprgb_pkg::MODE_DIRECT) begin
      job.data = {8'h00, bmprgb_pkg::to_rgb565({data_byte, held_r})};
    end else begin
      job.data = {16'h0000, data_byte};
    end
  end

  // row state update on each accepted data byte
  always_comb begin
    sc_nxt    = sc_r;
    rbc_nxt   = rbc_r;
    phase_nxt = phase_r;
    held_nxt  = held_r;
    rbc_inc   = rbc_r + bmprgb_pkg::ROW_W'(1);
    if (take && is_data && depth_ok) begin
      if (in_row) begin
        if (emit) begin
          sc_nxt = sc_r + bmprgb_pkg::COL_W'(npix);
        end
        if (mode == bmprgb_pkg::MODE_DIRECT) begin
          case (phase_r)
            PH_BLUE: begin
              held_nxt  = {8'h00, data_byte};
              phase_nxt = PH_GREEN;
            end
            PH_GREEN: begin
              held_nxt  = {data_byte, held_r[7:0]};
              phase_nxt = PH_RED;
            end
            default: begin
              phase_nxt = PH_BLUE;
            end
          endcase
        end
      end
      if ({1'b0, rbc_inc} >= line) begin
        rbc_nxt   = '0;
        sc_nxt    = '0;
        phase_nxt = PH_BLUE;
      end else begin
        rbc_nxt = rbc_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_r    <= '0;
      rbc_r   <= '0;
      phase_r <= PH_BLUE;
      held_r  <= '0;
    end else begin
      sc_r    <= sc_nxt;
      rbc_r   <= rbc_nxt;
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
    end
  end

`ifndef SYNTH
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_BLUE || phase_r == PH_GREEN || phase_r == PH_RED)
    else $error("triplet phase out of range");
  a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    take && is_data && depth_ok && ({1'b0, rbc_inc} >= line) |=> rbc_r == '0 && sc_r == '0)
    else $error("row counters did not wrap at row end");
`endif

endmodule

// ===== rtl/core/bmprgb_pix_gen.sv =====
// ----------------------------------------------------------------------------
// bmprgb_pix_gen
// Pixel generator: holds one job, steps through its pixels and copies,
// reads the palette RAM and drives the registered result stage.
// ----------------------------------------------------------------------------
module bmprgb_pix_gen #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bmprgb_pkg::job_t                  job_in,
  input  logic                              job_load,
  output logic                              job_ready,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [bmprgb_pkg::PIX_W-1:0]      out_pixel,
  output logic [bmprgb_pkg::OCOL_W-1:0]     out_col,
  output logic                              out_eor,
  output logic                              out_last
);

  localparam int PAL_AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  bmprgb_pkg::job_t                 job_r;
  logic                             job_v_r;
  logic [2:0]                       p_r;
  logic                             k_r;
  logic                             is_pix;
  logic                             last_pix;
  logic                             last_step;
  logic                             go;
  logic                             done;
  logic                             r_ready;
  logic                             o_ready;
  logic                             rd_en;
  logic                             wr_en;
  logic                             oob;
  logic [bmprgb_pkg::BYTE_W-1:0]    src_byte;
  logic [bmprgb_pkg::BYTE_W-1:0]    rd_idx;
  logic [PAL_AW-1:0]                ram_addr;
  logic [bmprgb_pkg::COLOR_W-1:0]   ram_rdata;
  logic [bmprgb_pkg::COL_W-1:0]     col_src;
  logic [bmprgb_pkg::OCOL_W-1:0]    col;

  // read stage
  logic                             r_v_r;
  logic                             r_direct_r;
  logic                             r_oob_r;
  logic [bmprgb_pkg::PIX_W-1:0]     r_pix_r;
  logic [bmprgb_pkg::OCOL_W-1:0]    r_col_r;
  logic                             r_eor_r;
  logic                             r_last_r;
  logic [bmprgb_pkg::PIX_W-1:0]     r_color;

  // result stage
  logic                             out_v_r;
  logic [bmprgb_pkg::PIX_W-1:0]     out_pix_r;
  logic [bmprgb_pkg::OCOL_W-1:0]    out_col_r;
  logic                             out_eor_r;
  logic                             out_last_r;

  // step control
  assign is_pix    = (job_r.kind == bmprgb_pkg::JOB_PIXELS);
  assign last_pix  = ({1'b0, p_r} == (job_r.npix - 4'd1));
  assign last_step = last_pix && (k_r == job_r.scale2);
  assign o_ready   = !out_v_r || out_ready;
  assign r_ready   = !r_v_r || o_ready;
  assign go        = job_v_r && (!is_pix || r_ready);
  assign done      = go && (!is_pix || last_step);
  assign job_ready = !job_v_r || done;

  // palette index of the current pixel
  assign src_byte = job_r.data[bmprgb_pkg::BYTE_W-1:0];
  always_comb begin
    case (job_r.mode)
      bmprgb_pkg::MODE_PAL4: rd_idx = (p_r[0] == 1'b0) ? {4'h0, src_byte[7:4]}
                                                       : {4'h0, src_byte[3:0]};
      bmprgb_pkg::MODE_PAL1: rd_idx = {7'h00, src_byte[3'd7 - p_r]};
      default:               rd_idx = src_byte;
    endcase
  end

  // entries beyond the palette read as zero, writes there are dropped
  assign oob      = {1'b0, rd_idx} >= 9'(PALETTE_DEPTH);
  assign wr_en    = job_v_r && !is_pix && ({1'b0, job_r.wr_index} < 9'(PALETTE_DEPTH));
  assign rd_en    = go && is_pix && (job_r.mode != bmprgb_pkg::MODE_DIRECT);
  assign ram_addr = is_pix ? rd_idx[PAL_AW-1:0] : job_r.wr_index[PAL_AW-1:0];

  // output column, doubled when scaling
  assign col_src = job_r.start_col + bmprgb_pkg::COL_W'(p_r);
  assign col     = job_r.scale2 ? {col_src[8:0], k_r} : col_src[9:0];

  bmprgb_ram #(
    .WIDTH (bmprgb_pkg::COLOR_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_pal (
    .clk   (clk),
    .we    (wr_en),
    .re    (rd_en),
    .addr  (ram_addr),
    .wdata (job_r.data),
    .rdata (ram_rdata)
  );

  // job register and step counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_v_r <= 1'b0;
      p_r     <= '0;
      k_r     <= 1'b0;
    end else if (job_load) begin
      job_v_r <= 1'b1;
      p_r     <= '0;
      k_r     <= 1'b0;
    end else if (done) begin
      job_v_r <= 1'b0;
    end else if (go && is_pix) begin
      if (k_r != job_r.scale2) begin
        k_r <= 1'b1;
      end else begin
        k_r <= 1'b0;
        p_r <= p_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_load) begin
      job_r <= job_in;
    end
  end

  // read stage, lined up with the registered RAM data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_v_r <= 1'b0;
    end else if (r_ready) begin
      r_v_r <= go && is_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (r_ready && go && is_pix) begin
      r_direct_r <= (job_r.mode == bmprgb_pkg::MODE_DIRECT);
      r_oob_r    <= oob;
      r_pix_r    <= job_r.data[bmprgb_pkg::PIX_W-1:0];
      r_col_r    <= col;
      r_eor_r    <= job_r.row_end && last_step;
      r_last_r   <= last_step;
    end
  end

  assign r_color = r_direct_r ? r_pix_r
                 : (r_oob_r ? '0 : bmprgb_pkg::to_rgb565(ram_rdata));

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (o_ready) begin
      out_v_r <= r_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (o_ready && r_v_r) begin
      out_pix_r  <= r_color;
      out_col_r  <= r_col_r;
      out_eor_r  <= r_eor_r;
      out_last_r <= r_last_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_pixel = out_pix_r;
  assign out_col   = out_col_r;
  assign out_eor   = out_eor_r;
  assign out_last  = out_last_r;

`ifndef SYNTH
  a_npix_range: assert property (@(posedge clk) disable iff (!rst_n)
    job_v_r && is_pix |-> job_r.npix != 4'd0 && job_r.npix <= 4'd8)
    else $error("pixel job with bad pixel count");
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    job_v_r && is_pix |-> {1'b0, p_r} < job_r.npix)
    else $error("pixel step ran past the job");
  a_scale_cols: assert property (@(posedge clk) disable iff (!rst_n)
    job_v_r && is_pix && job_r.scale2 |->
      (job_r.start_col + bmprgb_pkg::COL_W'(job_r.npix)) <= bmprgb_pkg::SCALE_MAX_WIDTH)
    else $error("doubled row wider than allowed");
`endif

endmodule

// ===== rtl/core/bmp_row_to_rgb565.sv =====
// ----------------------------------------------------------------------------
// bmp_row_to_rgb565
// Decodes bottom-up BMP row bytes (24-bit BGR or 1/4/8-bit palette) into
// RGB565 pixels, optionally doubled horizontally, with palette writes
// carried in order on the same input channel.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  in_ch     in   valid/ready        req_type, palette_index, palette_color,
//                                    data_byte
//  out_ch    out  valid/ready        pixel, out_column, end_of_row, last_of_item
//  cfg_*     in   cfg_we, no wait    cfg_index, cfg_wdata
//
//  the generator steps through the pixels of an item one at a time, set by
//  its single pixel step and its one palette read port (a 1-bit byte at
//  double scale gives up to 16 pixels); the next item is taken as the last step ends
//  pixels of an accepted item pass the job register, read stage and result register
//  reset is synchronous and active low; the palette is not cleared
//  a stall on out_ch holds the result, read and job stages, then in_ch.ready
// ----------------------------------------------------------------------------
module bmp_row_to_rgb565 #(
  parameter int MAX_WIDTH     = 1024,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  bmprgb_in_if.sink                             in_ch,
  bmprgb_out_if.source                          out_ch,
  input  logic                                  cfg_we,
  input  logic [bmprgb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bmprgb_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  logic [bmprgb_pkg::DEPTH_W-1:0]  bit_depth_r;
  logic [bmprgb_pkg::COL_W-1:0]    image_width_r;
  logic [bmprgb_pkg::SCALE_W-1:0]  scale_r;
  bmprgb_pkg::job_t                job;
  logic                            job_v;
  logic                            job_ready;
  logic                            accept;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_depth_r   <= bmprgb_pkg::RST_BIT_DEPTH;
      image_width_r <= bmprgb_pkg::RST_WIDTH;
      scale_r       <= bmprgb_pkg::RST_SCALE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bmprgb_pkg::REG_BIT_DEPTH:   bit_depth_r   <= cfg_wdata[bmprgb_pkg::DEPTH_W-1:0];
        bmprgb_pkg::REG_IMAGE_WIDTH: image_width_r <= cfg_wdata[bmprgb_pkg::COL_W-1:0];
        bmprgb_pkg::REG_SCALE:       scale_r       <= cfg_wdata[bmprgb_pkg::SCALE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_ch.ready = job_ready;
  assign accept      = in_ch.valid && job_ready;

  bmprgb_row_trk #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_row_trk (
    .clk           (clk),
    .rst_n         (rst_n),
    .bit_depth     (bit_depth_r),
    .image_width   (image_width_r),
    .scale_request (scale_r),
    .take          (accept),
    .req_type      (in_ch.req_type),
    .palette_index (in_ch.palette_index),
    .palette_color (in_ch.palette_color),
    .data_byte     (in_ch.data_byte),
    .job           (job),
    .job_v         (job_v)
  );

  bmprgb_pix_gen #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_pix_gen (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_in    (job),
    .job_load  (accept && job_v),
    .job_ready (job_ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_pixel (out_ch.pixel),
    .out_col   (out_ch.out_column),
    .out_eor   (out_ch.end_of_row),
    .out_last  (out_ch.last_of_item)
  );

endmodule
